@@ rtl/tmp_pkg.sv @@
`default_nettype none
package tmp_pkg;

    typedef struct packed {
        logic               command;
        logic signed [31:0] start_position;
        logic signed [31:0] target_position;
        logic signed [31:0] start_velocity;
        logic signed [31:0] end_velocity;
        logic        [31:0] time_stamp;
    } tmp_in_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic        [1:0]  phase;
    } tmp_out_t;

    localparam logic       CMD_PLAN = 1'b0;
    localparam logic [1:0] REG_MAX_VELOCITY = 2'd0;
    localparam logic [1:0] REG_MAX_ACCEL    = 2'd1;
    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Shared unit operations.
    typedef enum logic [2:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } tmp_op_t;

    typedef struct packed {
        logic               start;
        tmp_op_t            op;
        logic signed [66:0] a;
        logic signed [66:0] b;
    } tmp_req_t;

    typedef enum logic [1:0] {
        U_IDLE,
        U_BUSY,
        U_DONE
    } tmp_ustate_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_P_DIFF0, S_P_DIFF1, S_P_GAPDIV, S_P_GAP,
        S_P_DT1DIV, S_P_DT3DIV,
        S_P_X1A, S_P_X1B, S_P_X1C,
        S_P_X3A, S_P_X3B, S_P_X3C,
        S_P_NUM, S_P_LIN, S_P_HALF, S_P_SQRT,
        S_P_T1B, S_P_T3B, S_P_DT2,
        S_P_Y1A, S_P_Y1B, S_P_Y1C, S_P_Y2, S_P_FIN,
        S_E_SEL, S_E_M1, S_E_M2, S_E_M3, S_E_FIN,
        S_OUT
    } tmp_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        if (v > 67'sd2147483647)
            return S32_MAX;
        else if (v < -67'sd2147483648)
            return S32_MIN;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/trapezoidal_motion_profile.sv @@
`default_nettype none
// Trapezoidal motion profile generator, signed Q16.16.
// Input channel in_valid/in_ready carries a plan item (command 0) or an
// evaluate item (command 1); each gives exactly one result item on the
// out_valid/out_ready channel. Limits are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle, as
// the block does not enforce it. Index 0 is the velocity limit, 1 acceleration.
// One item is handled at a time by a sequencer that drives a single shared
// shift-add multiplier, restoring divider and square-root unit. An evaluate
// item chains up to three multiplies; a plan item chains the multiply,
// divide and square-root steps.
// The result sits in an output register; a stalled receiver holds it there
// and the next item is accepted while it waits, its result parked in the
// sequencer until the register frees.
// Reset clears the profile state to all zero with the phase finished and
// loads the default limits.
module trapezoidal_motion_profile
    import tmp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire tmp_in_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output tmp_out_t   out_data,
    input  wire logic  cfg_we,
    input  wire logic  cfg_index,
    input  wire logic [30:0] cfg_data
);

    logic [30:0]        vmax_reg;
    logic [30:0]        amax_reg;
    logic               ov_reg, ov_next;
    tmp_out_t           od_reg;
    tmp_req_t           req;
    logic               alu_done;
    logic signed [66:0] alu_result;
    logic               busy;
    logic               out_load;
    tmp_out_t           seq_item;
    logic               out_free;
    logic               in_fire;

    assign in_ready = !busy;
    assign in_fire = in_valid && in_ready;
    assign out_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_data = od_reg;
    assign ov_next = out_load ? 1'b1 : (out_ready ? 1'b0 : ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmax_reg <= 31'd6554;
            amax_reg <= 31'd655;
            ov_reg   <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            if (cfg_we && cfg_index == REG_MAX_VELOCITY[0])
                vmax_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_MAX_ACCEL[0])
                amax_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            od_reg <= seq_item;
    end

    tmp_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .done   (alu_done),
        .result (alu_result)
    );

    tmp_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_data),
        .in_fire    (in_fire),
        .vmax       (vmax_reg),
        .amax       (amax_reg),
        .alu_done   (alu_done),
        .alu_result (alu_result),
        .out_free   (out_free),
        .req        (req),
        .busy       (busy),
        .out_load   (out_load),
        .out_item   (seq_item)
    );

endmodule
`default_nettype wire

@@ rtl/tmp_alu.sv @@
`default_nettype none
// Shared multiply / divide / square-root unit. Multiplication is a
// shift-add, division restoring, square root one bit pair per cycle.
// Division and square root return truncated integer results.
module tmp_alu
    import tmp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tmp_req_t           req,
    output logic                    done,
    output logic signed [66:0]      result
);

    tmp_ustate_t state_reg, state_next;
    tmp_op_t     op_reg, op_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [65:0] acc_reg, acc_next;   // product / remainder / root work
    logic [65:0] opa_reg, opa_next;   // multiplicand / dividend / radicand
    logic [65:0] opb_reg, opb_next;   // multiplier / divisor
    logic [63:0] quo_reg, quo_next;
    logic        neg_reg, neg_next;

    logic [65:0] mag_a;
    logic [65:0] mag_b;
    logic [66:0] trial;
    logic [65:0] rem_sh;
    logic [65:0] sq_try;

    always_comb
    begin
        mag_a = req.a[66] ? 66'(-req.a) : req.a[65:0];
        mag_b = req.b[66] ? 66'(-req.b) : req.b[65:0];
        rem_sh = {acc_reg[64:0], opa_reg[63]};
        trial = {1'b0, rem_sh} - {1'b0, opb_reg};
        sq_try = {quo_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        opa_next = opa_reg;
        opb_next = opb_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        done = 1'b0;
        result = '0;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    state_next = U_BUSY;
                    op_next = req.op;
                    acc_next = '0;
                    quo_next = '0;
                    neg_next = req.a[66] ^ req.b[66];
                    opa_next = mag_a;
                    opb_next = mag_b;
                    case (req.op)
                        OP_MUL:  cnt_next = 7'd33;
                        OP_DIV:
                        begin
                            cnt_next = 7'd64;
                            opa_next = {2'b00, mag_a[63:0]};
                        end
                        OP_SQRT:
                        begin
                            cnt_next = 7'd32;
                            neg_next = 1'b0;
                        end
                        default: cnt_next = 7'd1;
                    endcase
                end
            end
            U_BUSY:
            begin
                cnt_next = cnt_reg - 7'd1;
                case (op_reg)
                    OP_MUL:
                    begin
                        if (opb_reg[0])
                            acc_next = acc_reg + opa_reg;
                        opa_next = {opa_reg[64:0], 1'b0};
                        opb_next = {1'b0, opb_reg[65:1]};
                    end
                    OP_DIV:
                    begin
                        opa_next = {opa_reg[64:0], 1'b0};
                        if (!trial[66])
                        begin
                            acc_next = trial[65:0];
                            quo_next = {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            acc_next = rem_sh;
                            quo_next = {quo_reg[62:0], 1'b0};
                        end
                    end
                    OP_SQRT:
                    begin
                        opa_next = {opa_reg[63:0], 2'b00};
                        if ({acc_reg[63:0], opa_reg[63:62]} >= sq_try)
                        begin
                            acc_next = {acc_reg[63:0], opa_reg[63:62]} - sq_try;
                            quo_next = {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            acc_next = {acc_reg[63:0], opa_reg[63:62]};
                            quo_next = {quo_reg[62:0], 1'b0};
                        end
                    end
                    default: ;
                endcase
                if (cnt_reg == 7'd1)
                    state_next = U_DONE;
            end
            U_DONE:
            begin
                done = 1'b1;
                state_next = U_IDLE;
                case (op_reg)
                    OP_MUL:
                        result = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
                    OP_DIV:
                        result = neg_reg ? -$signed({3'b000, quo_reg})
                                         : $signed({3'b000, quo_reg});
                    default:
                        result = $signed({3'b000, quo_reg});
                endcase
            end
            default: state_next = U_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/tmp_seq.sv @@
`default_nettype none
// Sequencer: walks the plan and evaluate recipes through the shared unit.
module tmp_seq
    import tmp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tmp_in_t            in_item,
    input  wire logic               in_fire,
    input  wire logic [30:0]        vmax,
    input  wire logic [30:0]        amax,
    input  wire logic               alu_done,
    input  wire logic signed [66:0] alu_result,
    input  wire logic               out_free,
    output tmp_req_t                req,
    output logic                    busy,
    output logic                    out_load,
    output tmp_out_t                out_item
);

    tmp_state_t state_reg, state_next;
    logic                    wait_reg, wait_next;
    logic        [31:0]      ptime_reg, ptime_next;
    logic signed [31:0]      org_reg, org_next;
    logic signed [31:0]      goal_reg, goal_next;
    logic signed [31:0]      vs_reg, vs_next;
    logic signed [31:0]      ve_reg, ve_next;
    logic signed [31:0]      acc_reg, acc_next;
    logic signed [31:0]      vc_reg, vc_next;
    logic signed [31:0]      t1_reg, t1_next;
    logic signed [31:0]      t2_reg, t2_next;
    logic signed [31:0]      t3_reg, t3_next;
    logic signed [31:0]      y1_reg, y1_next;
    logic signed [31:0]      y2_reg, y2_next;
    logic        [1:0]       ph_reg, ph_next;
    tmp_in_t                 item_reg, item_next;
    logic signed [66:0]      ta_reg, ta_next;
    logic signed [66:0]      tb_reg, tb_next;
    logic signed [66:0]      tc_reg, tc_next;
    logic signed [31:0]      sgn_reg, sgn_next;
    logic signed [31:0]      dt1_reg, dt1_next;
    logic signed [31:0]      dt2_reg, dt2_next;
    logic signed [31:0]      dt3_reg, dt3_next;
    logic signed [31:0]      t_reg, t_next;
    tmp_out_t                res_reg, res_next;

    logic signed [66:0] av;
    logic signed [66:0] quot;
    logic signed [66:0] dnum;
    logic signed [66:0] plim;
    logic signed [31:0] sa;
    logic signed [31:0] s_vc;
    logic signed [31:0] dec;
    logic signed [31:0] rel;
    logic signed [31:0] abs_q;
    logic signed [66:0] tail;

    assign busy = (state_reg != S_IDLE);
    assign out_item = res_reg;
    assign sa = sgn_reg[31] ? -$signed({1'b0, amax}) : $signed({1'b0, amax});
    assign s_vc = sgn_reg[31] ? -$signed({1'b0, vmax}) : $signed({1'b0, vmax});
    assign dec = sat32(-67'(acc_reg));
    assign rel = t_reg;
    assign plim = 67'sd70368744177664;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            ptime_reg <= '0;
            org_reg   <= '0;
            goal_reg  <= '0;
            vs_reg    <= '0;
            ve_reg    <= '0;
            acc_reg   <= '0;
            vc_reg    <= '0;
            t1_reg    <= '0;
            t2_reg    <= '0;
            t3_reg    <= '0;
            y1_reg    <= '0;
            y2_reg    <= '0;
            ph_reg    <= PH_DONE;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            ptime_reg <= ptime_next;
            org_reg   <= org_next;
            goal_reg  <= goal_next;
            vs_reg    <= vs_next;
            ve_reg    <= ve_next;
            acc_reg   <= acc_next;
            vc_reg    <= vc_next;
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            t3_reg    <= t3_next;
            y1_reg    <= y1_next;
            y2_reg    <= y2_next;
            ph_reg    <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        ta_reg   <= ta_next;
        tb_reg   <= tb_next;
        tc_reg   <= tc_next;
        sgn_reg  <= sgn_next;
        dt1_reg  <= dt1_next;
        dt2_reg  <= dt2_next;
        dt3_reg  <= dt3_next;
        t_reg    <= t_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        wait_next = wait_reg;
        ptime_next = ptime_reg;
        org_next = org_reg;
        goal_next = goal_reg;
        vs_next = vs_reg;
        ve_next = ve_reg;
        acc_next = acc_reg;
        vc_next = vc_reg;
        t1_next = t1_reg;
        t2_next = t2_reg;
        t3_next = t3_reg;
        y1_next = y1_reg;
        y2_next = y2_reg;
        ph_next = ph_reg;
        item_next = item_reg;
        ta_next = ta_reg;
        tb_next = tb_reg;
        tc_next = tc_reg;
        sgn_next = sgn_reg;
        dt1_next = dt1_reg;
        dt2_next = dt2_reg;
        dt3_next = dt3_reg;
        t_next = t_reg;
        res_next = res_reg;
        req = '0;
        out_load = 1'b0;
        av = alu_result;
        quot = '0;
        dnum = '0;
        abs_q = '0;
        tail = '0;

        // A unit call: issue once, then wait for done.
        case (state_reg)
            S_IDLE:
            begin
                wait_next = 1'b0;
                if (in_fire)
                begin
                    item_next = in_item;
                    if (in_item.command == CMD_PLAN)
                        state_next = S_P_DIFF0;
                    else
                    begin
                        t_next = in_item.time_stamp - ptime_reg;
                        state_next = S_E_SEL;
                    end
                end
            end

            // diff = ve^2 - vs^2
            S_P_DIFF0:
            begin
                req.op = OP_MUL;
                req.a = 67'(item_reg.end_velocity);
                req.b = 67'(item_reg.end_velocity);
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    ta_next = av;
                    state_next = S_P_DIFF1;
                end
            end
            S_P_DIFF1:
            begin
                req.op = OP_MUL;
                req.a = 67'(item_reg.start_velocity);
                req.b = 67'(item_reg.start_velocity);
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    ta_next = ta_reg - av;
                    tc_next = av;      // vs^2 kept for the triangular case
                    state_next = (amax == '0) ? S_P_GAP : S_P_GAPDIV;
                end
            end
            // diff / (2A), raw integer quotient; unit divides by |b| after
            // shifting the dividend left by 0 here (raw form).
            S_P_GAPDIV:
            begin
                req.op = OP_DIV;
                req.a = ta_reg;
                req.b = 67'({amax, 1'b0}) <<< 0;
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    tb_next = 67'(item_reg.target_position) - 67'(item_reg.start_position) - av;
                    state_next = S_P_GAP;
                end
            end
            S_P_GAP:
            begin
                if (amax == '0)
                begin
                    if (ta_reg > 0)
                        sgn_next = -32'sd1;
                    else if (ta_reg < 0)
                        sgn_next = 32'sd1;
                    else
                        sgn_next = ((67'(item_reg.target_position)
                                     - 67'(item_reg.start_position)) < 0) ? -32'sd1 : 32'sd1;
                end
                else
                    sgn_next = (tb_reg < 0) ? -32'sd1 : 32'sd1;
                state_next = S_P_DT1DIV;
            end

            // dt1 = |divq(vc - vs, a)|, the dividend pre-shifted by 16.
            S_P_DT1DIV, S_P_T1B:
            begin
                dnum = (state_reg == S_P_DT1DIV) ? (67'(s_vc) - 67'(item_reg.start_velocity))
                                                 : (67'(vc_reg) - 67'(item_reg.start_velocity));
                req.op = OP_DIV;
                req.a = dnum <<< 16;
                req.b = 67'(sa);
                req.start = !wait_reg && (sa != 0);
                wait_next = (sa != 0);
                if (alu_done || sa == 0)
                begin
                    wait_next = 1'b0;
                    if (sa == 0)
                        quot = (dnum > 0) ? 67'(S32_MAX) : ((dnum < 0) ? 67'(S32_MIN) : '0);
                    else
                        quot = av;
                    abs_q = sat32(quot);
                    dt1_next = sat32(abs_q[31] ? -67'(abs_q) : 67'(abs_q));
                    state_next = (state_reg == S_P_DT1DIV) ? S_P_DT3DIV : S_P_T3B;
                end
            end
            S_P_DT3DIV, S_P_T3B:
            begin
                dnum = (state_reg == S_P_DT3DIV) ? 67'(s_vc) : 67'(vc_reg);
                req.op = OP_DIV;
                req.a = dnum <<< 16;
                req.b = 67'(sa);
                req.start = !wait_reg && (sa != 0);
                wait_next = (sa != 0);
                if (alu_done || sa == 0)
                begin
                    wait_next = 1'b0;
                    if (sa == 0)
                        quot = (dnum > 0) ? 67'(S32_MAX) : ((dnum < 0) ? 67'(S32_MIN) : '0);
                    else
                        quot = av;
                    abs_q = sat32(quot);
                    dt3_next = sat32(abs_q[31] ? -67'(abs_q) : 67'(abs_q));
                    if (state_reg == S_P_DT3DIV)
                    begin
                        vc_next = s_vc;
                        state_next = S_P_X1A;
                    end
                    else
                    begin
                        dt2_next = '0;
                        state_next = S_P_Y1A;
                    end
                end
            end

            // dx1 = vs*dt1 + ((a*dt1)*dt1)/2 ; shared shape for dx3 and y1.
            S_P_X1A, S_P_X3A, S_P_Y1A:
            begin
                req.op = OP_MUL;
                req.a = 67'(item_reg.start_velocity);
                req.b = 67'(dt1_reg);
                if (state_reg == S_P_X3A)
                begin
                    req.a = 67'(vc_reg);
                    req.b = 67'(dt3_reg);
                end
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    tb_next = 67'(sat32(av >>> 16));
                    if (av < 0)
                        tb_next = 67'(sat32(-((-av) >>> 16)));
                    state_next = tmp_state_t'(state_reg + 6'd1);
                end
            end
            S_P_X1B, S_P_X3B, S_P_Y1B:
            begin
                req.op = OP_MUL;
                req.a = 67'(sa);
                req.b = 67'(dt1_reg);
                if (state_reg == S_P_X3B)
                begin
                    req.a = -67'(sa);
                    req.b = 67'(dt3_reg);
                end
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    if (av < 0)
                        ta_next = 67'(sat32(-((-av) >>> 16)));
                    else
                        ta_next = 67'(sat32(av >>> 16));
                    state_next = tmp_state_t'(state_reg + 6'd1);
                end
            end
            S_P_X1C, S_P_X3C, S_P_Y1C:
            begin
                req.op = OP_MUL;
                req.a = ta_reg;
                req.b = (state_reg == S_P_X3C) ? 67'(dt3_reg) : 67'(dt1_reg);
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    if (av < 0)
                        tail = 67'(sat32(-((-av) >>> 16)));
                    else
                        tail = 67'(sat32(av >>> 16));
                    // Halving truncates toward zero.
                    tail = (tail < 0) ? -((-tail) >>> 1) : (tail >>> 1);
                    case (state_reg)
                        S_P_X1C:
                        begin
                            tc_next = tc_reg;
                            ta_next = 67'(sat32(tb_reg + tail));   // dx1
                            dt2_next = 32'(ta_reg);
                            state_next = S_P_X3A;
                            // Keep dx1 apart from ta, which X3 reuses.
                            y2_next = sat32(tb_reg + tail);
                        end
                        S_P_X3C:
                        begin
                            tb_next = 67'(item_reg.target_position)
                                      - (67'(item_reg.start_position) + 67'(y2_reg)
                                         + 67'(sat32(tb_reg + tail)));
                            state_next = S_P_NUM;
                        end
                        default:
                        begin
                            y1_next = sat32(67'(item_reg.start_position) + tb_reg + tail);
                            state_next = S_P_Y2;
                        end
                    endcase
                end
            end
            S_P_NUM:
            begin
                if (tb_reg != 0 && ((tb_reg < 0) != vc_reg[31]))
                    state_next = S_P_LIN;
                else
                    state_next = S_P_DT2;
            end
            // lin = s*(tgt-p0)*A
            S_P_LIN:
            begin
                req.op = OP_MUL;
                req.a = sgn_reg[31] ? (67'(item_reg.start_position) - 67'(item_reg.target_position))
                                    : (67'(item_reg.target_position) - 67'(item_reg.start_position));
                req.b = 67'({1'b0, amax});
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    ta_next = av;
                    state_next = S_P_HALF;
                end
            end
            S_P_HALF:
            begin
                // vs^2 is non-negative, so halving is a shift.
                ta_next = ta_reg + (tc_reg >>> 1);
                if (ta_reg + (tc_reg >>> 1) < 0)
                    ta_next = '0;
                state_next = S_P_SQRT;
            end
            S_P_SQRT:
            begin
                req.op = OP_SQRT;
                req.a = ta_reg;
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    abs_q = (av > 67'(S32_MAX)) ? S32_MAX : av[31:0];
                    vc_next = sgn_reg[31] ? -abs_q : abs_q;
                    state_next = S_P_T1B;
                end
            end
            S_P_DT2:
            begin
                req.op = OP_DIV;
                dnum = (tb_reg > plim) ? plim : ((tb_reg < -plim) ? -plim : tb_reg);
                req.a = dnum <<< 16;
                req.b = 67'(vc_reg);
                req.start = !wait_reg && (vc_reg != 0);
                wait_next = (vc_reg != 0);
                if (alu_done || vc_reg == 0)
                begin
                    wait_next = 1'b0;
                    if (vc_reg == 0)
                        quot = (dnum > 0) ? 67'(S32_MAX) : ((dnum < 0) ? 67'(S32_MIN) : '0);
                    else
                        quot = av;
                    abs_q = sat32(quot);
                    dt2_next = sat32(abs_q[31] ? -67'(abs_q) : 67'(abs_q));
                    state_next = S_P_Y1A;
                end
            end
            // y2 = y1 + mulq(vc, dt2)
            S_P_Y2:
            begin
                req.op = OP_MUL;
                req.a = 67'(vc_reg);
                req.b = 67'(dt2_reg);
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    if (av < 0)
                        tail = 67'(sat32(-((-av) >>> 16)));
                    else
                        tail = 67'(sat32(av >>> 16));
                    y2_next = sat32(67'(y1_reg) + tail);
                    state_next = S_P_FIN;
                end
            end
            S_P_FIN:
            begin
                t1_next = dt1_reg;
                t2_next = sat32(67'(dt1_reg) + 67'(dt2_reg));
                t3_next = sat32(67'(sat32(67'(dt1_reg) + 67'(dt2_reg))) + 67'(dt3_reg));
                ptime_next = item_reg.time_stamp;
                org_next = item_reg.start_position;
                goal_next = item_reg.target_position;
                vs_next = item_reg.start_velocity;
                ve_next = item_reg.end_velocity;
                acc_next = sa;
                ph_next = PH_ACCEL;
                res_next.position = item_reg.start_position;
                res_next.velocity = item_reg.start_velocity;
                res_next.acceleration = sa;
                res_next.phase = PH_ACCEL;
                state_next = S_OUT;
            end

            // Evaluate: pick the phase and the relative time.
            S_E_SEL:
            begin
                if (rel <= t1_reg)
                    ph_next = PH_ACCEL;
                else if (rel <= t2_reg)
                begin
                    ph_next = PH_CRUISE;
                    t_next = 32'(67'(rel) - 67'(t1_reg));
                end
                else if (rel < t3_reg)
                begin
                    ph_next = PH_DECEL;
                    t_next = 32'(67'(rel) - 67'(t2_reg));
                end
                else
                begin
                    ph_next = PH_DONE;
                    t_next = 32'(67'(rel) - 67'(t3_reg));
                end
                state_next = S_E_M1;
            end
            // M1: v*t, where v is vs, vc, vc or ve per phase.
            S_E_M1:
            begin
                req.op = OP_MUL;
                case (ph_reg)
                    PH_ACCEL:  req.a = 67'(vs_reg);
                    PH_DONE:   req.a = 67'(ve_reg);
                    default:   req.a = 67'(vc_reg);
                endcase
                req.b = 67'(t_reg);
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    if (av < 0)
                        tb_next = 67'(sat32(-((-av) >>> 16)));
                    else
                        tb_next = 67'(sat32(av >>> 16));
                    state_next = (ph_reg == PH_ACCEL || ph_reg == PH_DECEL) ? S_E_M2 : S_E_FIN;
                end
            end
            // M2: acc*t, also the velocity increment.
            S_E_M2:
            begin
                req.op = OP_MUL;
                req.a = (ph_reg == PH_ACCEL) ? 67'(acc_reg) : 67'(dec);
                req.b = 67'(t_reg);
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    if (av < 0)
                        ta_next = 67'(sat32(-((-av) >>> 16)));
                    else
                        ta_next = 67'(sat32(av >>> 16));
                    state_next = S_E_M3;
                end
            end
            S_E_M3:
            begin
                req.op = OP_MUL;
                req.a = ta_reg;
                req.b = 67'(t_reg);
                req.start = !wait_reg;
                wait_next = 1'b1;
                if (alu_done)
                begin
                    wait_next = 1'b0;
                    if (av < 0)
                        tail = 67'(sat32(-((-av) >>> 16)));
                    else
                        tail = 67'(sat32(av >>> 16));
                    tc_next = (tail < 0) ? -((-tail) >>> 1) : (tail >>> 1);
                    state_next = S_E_FIN;
                end
            end
            S_E_FIN:
            begin
                res_next.phase = ph_reg;
                case (ph_reg)
                    PH_ACCEL:
                    begin
                        res_next.position = sat32(67'(org_reg) + tb_reg + tc_reg);
                        res_next.velocity = sat32(67'(vs_reg) + ta_reg);
                        res_next.acceleration = acc_reg;
                    end
                    PH_CRUISE:
                    begin
                        res_next.position = sat32(67'(y1_reg) + tb_reg);
                        res_next.velocity = vc_reg;
                        res_next.acceleration = '0;
                    end
                    PH_DECEL:
                    begin
                        res_next.position = sat32(67'(y2_reg) + tb_reg + tc_reg);
                        res_next.velocity = sat32(67'(vc_reg) + ta_reg);
                        res_next.acceleration = dec;
                    end
                    default:
                    begin
                        res_next.position = sat32(67'(goal_reg) + tb_reg);
                        res_next.velocity = ve_reg;
                        res_next.acceleration = '0;
                    end
                endcase
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
    import tmp_pkg::tmp_in_t;
    import tmp_pkg::tmp_out_t;
    import tmp_pkg::CMD_PLAN;
    import tmp_pkg::REG_MAX_VELOCITY;
    import tmp_pkg::REG_MAX_ACCEL;
    import tmp_pkg::PH_ACCEL;
    import tmp_pkg::PH_CRUISE;
    import tmp_pkg::PH_DECEL;
    import tmp_pkg::PH_DONE;

    localparam logic CMD_EVAL = ~CMD_PLAN;
    localparam int STALL_LIMIT = 20000;
    localparam longint Q_ONE = 65536;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    tmp_in_t in_data;
    logic out_valid;
    logic out_ready;
    tmp_out_t out_data;
    logic cfg_we;
    logic cfg_index;
    logic [30:0] cfg_data;

    trapezoidal_motion_profile DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Profile state kept by the predictor.
    logic [30:0] lim_vel;
    logic [30:0] lim_acc;
    logic [31:0] plan_stamp;
    longint org_pos, goal_pos, speed_in, speed_out, accel_s, speed_cr;
    longint end_t[3];
    longint knee_pos[2];
    logic [1:0] cur_phase;

    tmp_out_t motion_expected[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clamp32((clamp32(a) * clamp32(b)) / Q_ONE);
    endfunction

    function automatic longint qdiv(longint n, longint d);
        longint lim;
        lim = longint'(1) <<< 46;
        if (n > lim)
            n = lim;
        if (n < -lim)
            n = -lim;
        if (d == 0)
            return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 0);
        return clamp32((n * Q_ONE) / d);
    endfunction

    function automatic longint mag(longint v);
        v = clamp32(v);
        return clamp32(v < 0 ? -v : v);
    endfunction

    function automatic longint coast(longint p, longint v, longint a, longint t);
        return clamp32(p + qmul(v, t) + qmul(qmul(a, t), t) / 2);
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic plan_profile(longint p0, longint tgt, longint vs, longint ve);
        longint acc_lim, vel_lim, diff, gap, s, a, vc, dt1, dt2, dt3, dx1, dx3, num, y1;
        longint lin, half, r;
        longint unsigned rad, peak;
        acc_lim = lim_acc;
        vel_lim = lim_vel;
        diff = ve * ve - vs * vs;
        if (acc_lim != 0)
            gap = tgt - p0 - diff / (2 * acc_lim);
        else
            gap = diff > 0 ? -1 : (diff < 0 ? 1 : tgt - p0);
        s = gap < 0 ? -1 : 1;
        a = s * acc_lim;
        vc = s * vel_lim;
        dt1 = mag(qdiv(vc - vs, a));
        dt3 = mag(qdiv(vc, a));
        dx1 = coast(0, vs, a, dt1);
        dx3 = coast(0, vc, -a, dt3);
        num = tgt - (p0 + dx1 + dx3);
        if (num != 0 && ((num < 0) != (vc < 0)))
        begin
            // No room to cruise: triangular profile.
            lin = s * (tgt - p0) * acc_lim;
            half = (vs * vs) / 2;
            if (lin < 0)
            begin
                r = lin + half;
                rad = r > 0 ? longint'(r) : 0;
            end
            else
                rad = longint'(lin) + longint'(half);
            peak = root64(rad);
            if (peak > 64'd2147483647)
                peak = 64'd2147483647;
            vc = s * longint'(peak);
            dt2 = 0;
            dt1 = mag(qdiv(vc - vs, a));
            dt3 = mag(qdiv(vc, a));
        end
        else
            dt2 = mag(qdiv(num, vc));
        end_t[0] = dt1;
        end_t[1] = clamp32(dt1 + dt2);
        end_t[2] = clamp32(end_t[1] + dt3);
        y1 = coast(p0, vs, a, dt1);
        knee_pos[0] = y1;
        knee_pos[1] = clamp32(y1 + qmul(vc, dt2));
        org_pos = p0;
        goal_pos = tgt;
        speed_in = vs;
        speed_out = ve;
        accel_s = a;
        speed_cr = vc;
        cur_phase = PH_ACCEL;
    endtask

    task automatic predict_motion(tmp_in_t it);
        tmp_out_t res;
        longint t, pos, vel, acc, dec;
        int dt;
        if (it.command == CMD_PLAN)
        begin
            plan_stamp = it.time_stamp;
            plan_profile(it.start_position, it.target_position,
                it.start_velocity, it.end_velocity);
            pos = org_pos;
            vel = speed_in;
            acc = accel_s;
        end
        else
        begin
            dt = int'(it.time_stamp - plan_stamp);
            t = dt;
            if (t <= end_t[0])
            begin
                pos = coast(org_pos, speed_in, accel_s, t);
                vel = clamp32(speed_in + qmul(accel_s, t));
                acc = accel_s;
                cur_phase = PH_ACCEL;
            end
            else if (t <= end_t[1])
            begin
                pos = clamp32(knee_pos[0] + qmul(speed_cr, t - end_t[0]));
                vel = speed_cr;
                acc = 0;
                cur_phase = PH_CRUISE;
            end
            else if (t < end_t[2])
            begin
                dec = clamp32(-accel_s);
                pos = coast(knee_pos[1], speed_cr, dec, t - end_t[1]);
                vel = clamp32(speed_cr + qmul(dec, t - end_t[1]));
                acc = dec;
                cur_phase = PH_DECEL;
            end
            else
            begin
                pos = clamp32(goal_pos + qmul(speed_out, t - end_t[2]));
                vel = speed_out;
                acc = 0;
                cur_phase = PH_DONE;
            end
        end
        res.position = pos[31:0];
        res.velocity = vel[31:0];
        res.acceleration = acc[31:0];
        res.phase = cur_phase;
        motion_expected.push_back(res);
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(tmp_in_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_motion(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (motion_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(logic idx, logic [30:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_VELOCITY[0])
            lim_vel = val;
        else
            lim_acc = val;
    endtask

    function automatic tmp_in_t make_plan(int p0, int tgt, int vs, int ve, logic [31:0] ts);
        tmp_in_t it;
        it.command = CMD_PLAN;
        it.start_position = p0;
        it.target_position = tgt;
        it.start_velocity = vs;
        it.end_velocity = ve;
        it.time_stamp = ts;
        return it;
    endfunction

    function automatic tmp_in_t make_eval(logic [31:0] ts);
        tmp_in_t it;
        it.command = CMD_EVAL;
        it.start_position = $urandom;
        it.target_position = $urandom;
        it.start_velocity = $urandom;
        it.end_velocity = $urandom;
        it.time_stamp = ts;
        return it;
    endfunction

    // Result checker and watchdog.
    initial
    begin
        int stall;
        tmp_out_t exp_r;
        stall = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (motion_expected.size() == 0)
                begin
                    $error("result item with none expected");
                    errors++;
                end
                else
                begin
                    exp_r = motion_expected.pop_front();
                    if (out_data.position !== exp_r.position)
                    begin
                        $error("position: expected %0d, got %0d", exp_r.position,
                            out_data.position);
                        errors++;
                    end
                    if (out_data.velocity !== exp_r.velocity)
                    begin
                        $error("velocity: expected %0d, got %0d", exp_r.velocity,
                            out_data.velocity);
                        errors++;
                    end
                    if (out_data.acceleration !== exp_r.acceleration)
                    begin
                        $error("acceleration: expected %0d, got %0d", exp_r.acceleration,
                            out_data.acceleration);
                        errors++;
                    end
                    if (out_data.phase !== exp_r.phase)
                    begin
                        $error("phase: expected %0d, got %0d", exp_r.phase, out_data.phase);
                        errors++;
                    end
                end
            end
            if (stall > 0)
                stall--;
            else
                stall = pick_gap();
            out_ready <= (stall == 0);
        end
    end

    task automatic test_directed();
        logic [31:0] ts;
        // Before any plan the reset state gives zeros with the phase finished.
        send_item(make_eval(32'h1234_5678));
        send_item(make_plan(0, 0, 0, 0, 0));
        send_item(make_eval(100));
        send_item(make_plan(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'hFFFF_FFFF));
        send_item(make_eval(32'h0000_0010));
        send_item(make_plan(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'h8000_0000));
        send_item(make_eval(32'h7FFF_FFFF));
        // A normal move with a cruise phase, probed at each phase boundary.
        ts = 32'h0001_0000;
        send_item(make_plan(0, 32'sh0010_0000, 0, 0, ts));
        send_item(make_eval(ts + end_t[0][31:0]));
        send_item(make_eval(ts + end_t[0][31:0] + 1));
        send_item(make_eval(ts + end_t[1][31:0]));
        send_item(make_eval(ts + end_t[1][31:0] + 1));
        send_item(make_eval(ts + end_t[2][31:0] - 1));
        send_item(make_eval(ts + end_t[2][31:0]));
        send_item(make_eval(ts + end_t[2][31:0] + 32'h0010_0000));
        // A time stamp before the plan lies in the accelerate phase.
        send_item(make_eval(ts - 32'd100));
        // Short move that cannot reach cruise speed, in the negative direction.
        send_item(make_plan(32'sh0000_1000, -32'sh0000_1000, 32'sh0000_0800,
            -32'sh0000_0400, 32'hFFFF_FF00));
        send_item(make_eval(32'hFFFF_FF00 + end_t[0][31:0]));
        send_item(make_eval(32'hFFFF_FF00 + end_t[2][31:0] - 2));
        send_item(make_eval(32'h0000_0400));
        // End velocity far above start velocity turns the direction around.
        send_item(make_plan(0, 32'sh0001_0000, 0, 32'sh0100_0000, 0));
        send_item(make_eval(32'h0000_8000));
        drain();
    endtask

    task automatic test_random(int count);
        tmp_in_t it;
        longint span;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                it.command = 1'($urandom);
                it.start_position = $urandom;
                it.target_position = $urandom;
                it.start_velocity = $urandom;
                it.end_velocity = $urandom;
                it.time_stamp = $urandom;
                send_item(it);
            end
            else if (r < 20)
            begin
                it = make_plan(0, 0, 0, 0, $urandom);
                it.start_position = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
                it.target_position = it.start_position +
                    ($signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000);
                it.start_velocity = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
                it.end_velocity = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
                if ($urandom_range(0, 3) == 0)
                    it.start_position = $urandom;
                send_item(it);
            end
            else
            begin
                span = end_t[2] + end_t[2] / 4 + 16;
                if (span > 64'h7FFF_FFF0)
                    span = 64'h7FFF_FFF0;
                if ($urandom_range(0, 9) == 0)
                    send_item(make_eval($urandom));
                else
                    send_item(make_eval(plan_stamp + $urandom_range(0, span[31:0])));
            end
        end
        drain();
    endtask

    task automatic test_limits();
        write_limit(REG_MAX_VELOCITY[0], 31'd1);
        write_limit(REG_MAX_ACCEL[0], 31'd1);
        test_random(60);
        write_limit(REG_MAX_VELOCITY[0], 31'h7FFF_FFFF);
        write_limit(REG_MAX_ACCEL[0], 31'h7FFF_FFFF);
        test_random(80);
        write_limit(REG_MAX_ACCEL[0], 31'd1);
        test_random(60);
        write_limit(REG_MAX_VELOCITY[0], 31'd1);
        write_limit(REG_MAX_ACCEL[0], 31'h7FFF_FFFF);
        test_random(60);
    endtask

    task automatic test_random_settings();
        for (int k = 0; k < 4; k++)
        begin
            write_limit(REG_MAX_VELOCITY[0], 31'($urandom_range(1, 32'h0004_0000)));
            write_limit(REG_MAX_ACCEL[0], 31'($urandom_range(1, 32'h0004_0000)));
            quiet = (k == 1);
            test_random(140);
        end
        quiet = 0;
    endtask

    initial
    begin
        lim_vel = 31'd6554;
        lim_acc = 31'd655;
        plan_stamp = 0;
        org_pos = 0;
        goal_pos = 0;
        speed_in = 0;
        speed_out = 0;
        accel_s = 0;
        speed_cr = 0;
        end_t = '{0, 0, 0};
        knee_pos = '{0, 0};
        cur_phase = PH_DONE;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= 1'b0;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(120);
        test_limits();
        test_random_settings();
        drain();
        repeat (700) @(posedge clk);
        if (errors == 0 && motion_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/tmp_pkg.sv
rtl/tmp_alu.sv
rtl/tmp_seq.sv
rtl/trapezoidal_motion_profile.sv
tb/sv/tb_top.sv
